[rtl/tdb_pkg.sv]
package tdb_pkg;

    // Geometry of the text buffer.
    localparam int ROWS     = 4;
    localparam int COLUMNS  = 20;
    localparam int CELLS    = ROWS * COLUMNS;
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int ROW_W    = 2;
    localparam int COL_W    = 5;
    localparam int CHAR_W   = 8;
    localparam int OP_W     = 2;
    localparam int ROW_IN_W = 3;
    localparam int DEPTH    = 2;

    localparam logic [CHAR_W-1:0] SPACE_CODE = 8'h20;

    // Operation codes as they arrive on the request channel.
    typedef enum logic [OP_W-1:0] {
        OP_WRITE  = 2'd0,
        OP_SETPOS = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_STREAM = 2'd3
    } op_t;

    // Classified command kinds handed from the front end to the back end.
    typedef enum logic [2:0] {
        CMD_WRITE,
        CMD_SETPOS,
        CMD_CLEAR,
        CMD_STREAM,
        CMD_REPORT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [CHAR_W-1:0] ch;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } cmd_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_out;
        logic              last;
        logic              changed;
        logic [ROW_W-1:0]  out_row;
        logic [COL_W-1:0]  out_col;
        logic              error;
    } res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WCMP,
        ST_SRD,
        ST_SOUT
    } back_state_t;

    // Linear cell address of a row and column.
    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [ROW_W-1:0] r,
        input logic [COL_W-1:0] c
    );
        cell_addr = ADDR_W'(int'(r) * COLUMNS + int'(c));
    endfunction

endpackage

[rtl/tdb_in_if.sv]
interface tdb_in_if;
    logic                           valid;
    logic                           ready;
    logic [tdb_pkg::OP_W-1:0]       op;
    logic [tdb_pkg::CHAR_W-1:0]     char_in;
    logic [tdb_pkg::ROW_IN_W-1:0]   row_in;
    logic [tdb_pkg::COL_W-1:0]      col_in;

    modport source (output valid, output op, output char_in, output row_in, output col_in,
                    input ready);
    modport sink   (input valid, input op, input char_in, input row_in, input col_in,
                    output ready);
endinterface

[rtl/tdb_out_if.sv]
interface tdb_out_if;
    logic                           valid;
    logic                           ready;
    logic [tdb_pkg::CHAR_W-1:0]     char_out;
    logic                           last;
    logic                           changed;
    logic [tdb_pkg::ROW_W-1:0]      out_row;
    logic [tdb_pkg::COL_W-1:0]      out_col;
    logic                           error;

    modport source (output valid, output char_out, output last, output changed,
                    output out_row, output out_col, output error, input ready);
    modport sink   (input valid, input char_out, input last, input changed,
                    input out_row, input out_col, input error, output ready);
endinterface

[rtl/tdb_front.sv]
module tdb_front (
    input  logic           clk,
    input  logic           rst_n,
    tdb_in_if.sink         req,
    output tdb_pkg::cmd_t  cmd,
    output logic           cmd_valid,
    input  logic           cmd_pop
);

    tdb_pkg::cmd_t cmd_new;
    tdb_pkg::cmd_t q_reg [tdb_pkg::DEPTH];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic          push;

    // Classify the incoming transaction and check its ranges.
    always_comb
    begin
        cmd_new.kind = tdb_pkg::CMD_REPORT;
        cmd_new.ch   = req.char_in;
        cmd_new.row  = tdb_pkg::ROW_W'(req.row_in);
        cmd_new.col  = req.col_in;
        case (tdb_pkg::op_t'(req.op))
            tdb_pkg::OP_WRITE:
            begin
                cmd_new.kind = tdb_pkg::CMD_WRITE;
            end
            tdb_pkg::OP_SETPOS:
            begin
                cmd_new.row = tdb_pkg::ROW_W'(req.row_in - tdb_pkg::ROW_IN_W'(1));
                if (req.row_in == '0 || req.row_in > tdb_pkg::ROW_IN_W'(tdb_pkg::ROWS)
                    || req.col_in >= tdb_pkg::COL_W'(tdb_pkg::COLUMNS))
                begin
                    cmd_new.kind = tdb_pkg::CMD_REPORT;
                end
                else
                begin
                    cmd_new.kind = tdb_pkg::CMD_SETPOS;
                end
            end
            tdb_pkg::OP_CLEAR:
            begin
                cmd_new.kind = tdb_pkg::CMD_CLEAR;
            end
            tdb_pkg::OP_STREAM:
            begin
                if (req.row_in >= tdb_pkg::ROW_IN_W'(tdb_pkg::ROWS))
                begin
                    cmd_new.kind = tdb_pkg::CMD_REPORT;
                end
                else
                begin
                    cmd_new.kind = tdb_pkg::CMD_STREAM;
                end
            end
            default:
            begin
                cmd_new.kind = tdb_pkg::CMD_REPORT;
            end
        endcase
    end

    // Two-entry command queue between the front and back ends.
    assign req.ready = (count_reg != 2'(tdb_pkg::DEPTH));
    assign push      = req.valid && req.ready;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (cmd_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !cmd_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (!push && cmd_pop)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

[rtl/tdb_back.sv]
module tdb_back (
    input  logic           clk,
    input  logic           rst_n,
    input  tdb_pkg::cmd_t  cmd,
    input  logic           cmd_valid,
    output logic           cmd_pop,
    tdb_out_if.source      rsp
);

    tdb_pkg::back_state_t          state_reg;
    tdb_pkg::back_state_t          state_next;

    logic [tdb_pkg::CHAR_W-1:0]    mem [tdb_pkg::CELLS];
    logic [tdb_pkg::CELLS-1:0]     valid_reg;
    logic [tdb_pkg::CHAR_W-1:0]    rd_data_reg;
    logic                          rd_valid_reg;

    logic [tdb_pkg::ROW_W-1:0]     cur_row_reg;
    logic [tdb_pkg::ROW_W-1:0]     cur_row_next;
    logic [tdb_pkg::COL_W-1:0]     cur_col_reg;
    logic [tdb_pkg::COL_W-1:0]     cur_col_next;
    logic                          dirty_reg;
    logic                          dirty_next;
    logic [tdb_pkg::COL_W-1:0]     cnt_reg;
    logic [tdb_pkg::COL_W-1:0]     cnt_next;
    logic [tdb_pkg::ROW_W-1:0]     srow_reg;
    logic [tdb_pkg::ROW_W-1:0]     srow_next;
    logic [tdb_pkg::CHAR_W-1:0]    wchar_reg;
    logic [tdb_pkg::CHAR_W-1:0]    wchar_next;

    logic                          res_valid_reg;
    tdb_pkg::res_t                 res_reg;
    tdb_pkg::res_t                 res_data;
    logic                          res_load;
    logic                          out_free;

    logic                          rd_en;
    logic [tdb_pkg::ADDR_W-1:0]    rd_addr;
    logic                          wr_en;
    logic                          clr_all;
    logic [tdb_pkg::ADDR_W-1:0]    cur_addr;
    logic [tdb_pkg::CHAR_W-1:0]    cur_char;
    logic [tdb_pkg::ROW_W-1:0]     adv_row;
    logic [tdb_pkg::COL_W-1:0]     adv_col;
    logic                          last_cell;
    logic [tdb_pkg::CHAR_W-1:0]    res_char;
    logic                          res_last;
    logic                          res_err;

    assign out_free  = !res_valid_reg || rsp.ready;
    assign cur_addr  = tdb_pkg::cell_addr(cur_row_reg, cur_col_reg);
    assign cur_char  = rd_valid_reg ? rd_data_reg : tdb_pkg::SPACE_CODE;
    assign last_cell = (cnt_reg == tdb_pkg::COL_W'(tdb_pkg::COLUMNS - 1));

    // Cursor position one cell further, wrapping at row and buffer ends.
    always_comb
    begin
        if (cur_col_reg == tdb_pkg::COL_W'(tdb_pkg::COLUMNS - 1))
        begin
            adv_col = '0;
            if (cur_row_reg == tdb_pkg::ROW_W'(tdb_pkg::ROWS - 1))
            begin
                adv_row = '0;
            end
            else
            begin
                adv_row = cur_row_reg + tdb_pkg::ROW_W'(1);
            end
        end
        else
        begin
            adv_col = cur_col_reg + tdb_pkg::COL_W'(1);
            adv_row = cur_row_reg;
        end
    end

    // Next-state logic of the execution sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tdb_pkg::ST_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    if (cmd.kind == tdb_pkg::CMD_WRITE)
                    begin
                        state_next = tdb_pkg::ST_WCMP;
                    end
                    else if (cmd.kind == tdb_pkg::CMD_STREAM)
                    begin
                        state_next = tdb_pkg::ST_SRD;
                    end
                end
            end
            tdb_pkg::ST_WCMP:
            begin
                if (out_free)
                begin
                    state_next = tdb_pkg::ST_IDLE;
                end
            end
            tdb_pkg::ST_SRD:
            begin
                state_next = tdb_pkg::ST_SOUT;
            end
            tdb_pkg::ST_SOUT:
            begin
                if (out_free)
                begin
                    state_next = last_cell ? tdb_pkg::ST_IDLE : tdb_pkg::ST_SRD;
                end
            end
            default:
            begin
                state_next = tdb_pkg::ST_IDLE;
            end
        endcase
    end

    // Control outputs and datapath next values of the sequencer.
    always_comb
    begin
        cmd_pop      = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = cur_addr;
        wr_en        = 1'b0;
        clr_all      = 1'b0;
        res_load     = 1'b0;
        res_char     = '0;
        res_last     = 1'b1;
        res_err      = 1'b0;
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        dirty_next   = dirty_reg;
        cnt_next     = cnt_reg;
        srow_next    = srow_reg;
        wchar_next   = wchar_reg;
        case (state_reg)
            tdb_pkg::ST_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.kind)
                        tdb_pkg::CMD_WRITE:
                        begin
                            rd_en      = 1'b1;
                            wchar_next = cmd.ch;
                        end
                        tdb_pkg::CMD_SETPOS:
                        begin
                            cur_row_next = cmd.row;
                            cur_col_next = cmd.col;
                            res_load     = 1'b1;
                        end
                        tdb_pkg::CMD_CLEAR:
                        begin
                            clr_all    = 1'b1;
                            dirty_next = 1'b1;
                            res_load   = 1'b1;
                        end
                        tdb_pkg::CMD_STREAM:
                        begin
                            srow_next = cmd.row;
                            cnt_next  = '0;
                            if (cmd.row == tdb_pkg::ROW_W'(tdb_pkg::ROWS - 1))
                            begin
                                dirty_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            res_err  = 1'b1;
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            tdb_pkg::ST_WCMP:
            begin
                if (out_free)
                begin
                    if (cur_char != wchar_reg)
                    begin
                        wr_en      = 1'b1;
                        dirty_next = 1'b1;
                    end
                    cur_row_next = adv_row;
                    cur_col_next = adv_col;
                    res_load     = 1'b1;
                end
            end
            tdb_pkg::ST_SRD:
            begin
                rd_en   = 1'b1;
                rd_addr = tdb_pkg::cell_addr(srow_reg, cnt_reg);
            end
            tdb_pkg::ST_SOUT:
            begin
                if (out_free)
                begin
                    res_load = 1'b1;
                    res_char = cur_char;
                    res_last = last_cell;
                    cnt_next = cnt_reg + tdb_pkg::COL_W'(1);
                end
            end
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase
        res_data.char_out = res_char;
        res_data.last     = res_last;
        res_data.changed  = dirty_next;
        res_data.out_row  = cur_row_next;
        res_data.out_col  = cur_col_next;
        res_data.error    = res_err;
    end

    // Cell memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[cur_addr] <= wchar_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Result payload register, plus the write character, cell count and stream row.
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res_data;
        end
        wchar_reg <= wchar_next;
        cnt_reg   <= cnt_next;
        srow_reg  <= srow_next;
    end

    // Control state, cursor, flag and per-cell written bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tdb_pkg::ST_IDLE;
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            dirty_reg     <= 1'b1;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
            dirty_reg   <= dirty_next;
            if (clr_all)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[cur_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid    = res_valid_reg;
    assign rsp.char_out = res_reg.char_out;
    assign rsp.last     = res_reg.last;
    assign rsp.changed  = res_reg.changed;
    assign rsp.out_row  = res_reg.out_row;
    assign rsp.out_col  = res_reg.out_col;
    assign rsp.error    = res_reg.error;

endmodule

[rtl/text_display_buffer_with_cursor.sv]
// A set-position, clear or rejected request passes through the command queue and then the
// result register; a character write first reads its cell, then compares and writes it.
// Writes are handled one at a time; other single-response requests go one per cycle while
// the response side is ready; a row refresh is dispatched, then each cell is read from
// memory and output in turn, and the next request waits until the row is done.
// Reset: asynchronous, active low; the buffer reads as all spaces at once through
// per-cell written bits, the cursor goes to the top left and the changed flag is set.
module text_display_buffer_with_cursor (
    input  logic       clk,
    input  logic       rst_n,
    tdb_in_if.sink     req,
    tdb_out_if.source  rsp
);

    tdb_pkg::cmd_t cmd;
    logic          cmd_valid;
    logic          cmd_pop;

    // Front end: classifies transactions and queues them.
    tdb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    // Back end: executes commands against the cell memory.
    tdb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .rsp       (rsp)
    );

endmodule

[verif/text_display_buffer_with_cursor_tb.sv]
module text_display_buffer_with_cursor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tdb_pkg::*;

    localparam int RANDOM_ITEMS       = 146;
    localparam int QUIET_TAIL_ITEMS   = 30;
    localparam int LONG_STALL_CYCLES  = 300;
    localparam int LONG_STALL_AT      = 45;
    localparam int DRAIN_LIMIT        = 100000;
    localparam int SETTLE_CYCLES      = 50;

    // One request as the sender offers it.
    typedef struct {
        op_t                 op;
        logic [CHAR_W-1:0]   ch;
        logic [ROW_IN_W-1:0] row;
        logic [COL_W-1:0]    col;
    } text_request_t;

    logic clk = 1'b0;
    logic rst_n;

    tdb_in_if  req_if ();
    tdb_out_if rsp_if ();

    text_display_buffer_with_cursor uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Shadow copy of the text buffer, cursor and changed flag.
    logic [CHAR_W-1:0] shadow_cells [0:CELLS-1];
    logic [ROW_W-1:0]  shadow_row;
    logic [COL_W-1:0]  shadow_col;
    logic              shadow_dirty;

    text_request_t pending_reqs [$];
    res_t          expected_responses [$];

    int  accepted_count = 0;
    int  sent_count     = 0;
    int  fail_count     = 0;
    int  send_gap       = 0;
    int  sink_gap       = 0;
    bit  long_stall     = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        fail_count++;
    endtask

    // Idling stops once only the last few requests are left.
    function automatic bit quiet_tail();
        return pending_reqs.size() < QUIET_TAIL_ITEMS;
    endfunction

    task automatic queue_request(input op_t op, input logic [CHAR_W-1:0] ch,
                                 input logic [ROW_IN_W-1:0] row, input logic [COL_W-1:0] col);
        text_request_t item;
        item.op  = op;
        item.ch  = ch;
        item.row = row;
        item.col = col;
        pending_reqs.push_back(item);
    endtask

    // Queue one expected response, reporting the shadow state as it stands now.
    task automatic push_display_response(input logic [CHAR_W-1:0] ch, input logic last,
                                         input logic err);
        res_t r;
        r.char_out = ch;
        r.last     = last;
        r.changed  = shadow_dirty;
        r.out_row  = shadow_row;
        r.out_col  = shadow_col;
        r.error    = err;
        expected_responses.push_back(r);
    endtask

    // Apply one accepted request to the shadow buffer and queue its responses.
    task automatic apply_display_request(input op_t op, input logic [CHAR_W-1:0] ch,
                                         input logic [ROW_IN_W-1:0] row,
                                         input logic [COL_W-1:0] col);
        int  idx;
        bit  bad;
        case (op)
            OP_WRITE:
            begin
                idx = int'(shadow_row) * COLUMNS + int'(shadow_col);
                if (shadow_cells[idx] != ch)
                begin
                    shadow_cells[idx] = ch;
                    shadow_dirty = 1'b1;
                end
                // Advance along the row, then to the next row, wrapping after the last cell.
                idx = idx + 1;
                if (idx < CELLS)
                begin
                    shadow_row = ROW_W'(idx / COLUMNS);
                    shadow_col = COL_W'(idx % COLUMNS);
                end
                else
                begin
                    shadow_row = '0;
                    shadow_col = '0;
                end
                push_display_response('0, 1'b1, 1'b0);
            end
            OP_SETPOS:
            begin
                bad = (row == 0) || (int'(row) > ROWS) || (int'(col) >= COLUMNS);
                if (!bad)
                begin
                    shadow_row = ROW_W'(int'(row) - 1);
                    shadow_col = col;
                end
                push_display_response('0, 1'b1, bad);
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < CELLS; i++)
                    shadow_cells[i] = SPACE_CODE;
                shadow_dirty = 1'b1;
                push_display_response('0, 1'b1, 1'b0);
            end
            default:
            begin
                if (int'(row) >= ROWS)
                    push_display_response('0, 1'b1, 1'b1);
                else
                begin
                    if (int'(row) == ROWS - 1)
                        shadow_dirty = 1'b0;
                    for (int i = 0; i < COLUMNS; i++)
                        push_display_response(shadow_cells[int'(row) * COLUMNS + i],
                                              i == COLUMNS - 1, 1'b0);
                end
            end
        endcase
    endtask

    // Random request, mostly well formed, with every field bit exercised.
    function automatic text_request_t make_random_request();
        text_request_t r;
        int sel;
        sel   = $urandom_range(0, 99);
        r.ch  = CHAR_W'($urandom_range(0, 255));
        r.row = ROW_IN_W'($urandom_range(0, 7));
        r.col = COL_W'($urandom_range(0, 31));
        if (sel < 40)
        begin
            r.op = OP_WRITE;
            // Reuse a few codes so that rewrites of the same character happen.
            if ($urandom_range(0, 2) == 0)
                r.ch = ($urandom_range(0, 1) == 0) ? SPACE_CODE : 8'h41;
        end
        else if (sel < 65)
        begin
            r.op = OP_SETPOS;
            if ($urandom_range(0, 4) != 0)
            begin
                r.row = ROW_IN_W'($urandom_range(1, ROWS));
                r.col = COL_W'($urandom_range(0, COLUMNS - 1));
            end
        end
        else if (sel < 70)
            r.op = OP_CLEAR;
        else
        begin
            r.op = OP_STREAM;
            if ($urandom_range(0, 5) != 0)
                r.row = ROW_IN_W'($urandom_range(0, ROWS - 1));
        end
        return r;
    endfunction

    // Request driver: holds each transaction until it is taken, with random gaps between.
    always @(negedge clk)
    begin
        text_request_t item;
        bit            busy;
        busy = req_if.valid && (accepted_count != sent_count);
        if (!busy)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                req_if.valid <= 1'b0;
            end
            else if (pending_reqs.size() == 0)
                req_if.valid <= 1'b0;
            else if (!quiet_tail() && !long_stall && $urandom_range(0, 9) == 0)
            begin
                send_gap = $urandom_range(0, 8);
                req_if.valid <= 1'b0;
            end
            else
            begin
                item = pending_reqs.pop_front();
                req_if.op      <= item.op;
                req_if.char_in <= item.ch;
                req_if.row_in  <= item.row;
                req_if.col_in  <= item.col;
                req_if.valid   <= 1'b1;
                sent_count++;
            end
        end
    end

    // Response ready driver with random stall bursts and one long hold-off.
    always @(negedge clk)
    begin
        if (long_stall)
            rsp_if.ready <= 1'b0;
        else if (sink_gap > 0)
        begin
            sink_gap--;
            rsp_if.ready <= 1'b0;
        end
        else if (!quiet_tail() && $urandom_range(0, 7) == 0)
        begin
            sink_gap = $urandom_range(0, 8);
            rsp_if.ready <= 1'b0;
        end
        else
            rsp_if.ready <= 1'b1;
    end

    // Long hold-off on the response side so the block backs up and stalls its input.
    initial
    begin
        while (accepted_count < LONG_STALL_AT)
            @(posedge clk);
        long_stall = 1'b1;
        repeat (LONG_STALL_CYCLES) @(posedge clk);
        long_stall = 1'b0;
    end

    // Monitor: predicts on each accepted request and checks each accepted response.
    always @(posedge clk)
    begin
        res_t got;
        res_t exp_r;
        if (rst_n && req_if.valid && req_if.ready)
        begin
            apply_display_request(op_t'(req_if.op), req_if.char_in, req_if.row_in,
                                  req_if.col_in);
            accepted_count++;
        end
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got.char_out = rsp_if.char_out;
            got.last     = rsp_if.last;
            got.changed  = rsp_if.changed;
            got.out_row  = rsp_if.out_row;
            got.out_col  = rsp_if.out_col;
            got.error    = rsp_if.error;
            if (expected_responses.size() == 0)
                report_mismatch($sformatf("response with no transaction expected: %p", got));
            else
            begin
                exp_r = expected_responses.pop_front();
                if (got.char_out !== exp_r.char_out)
                    report_mismatch($sformatf("char_out got %h expected %h",
                                              got.char_out, exp_r.char_out));
                if (got.last !== exp_r.last)
                    report_mismatch($sformatf("last got %b expected %b", got.last, exp_r.last));
                if (got.changed !== exp_r.changed)
                    report_mismatch($sformatf("changed got %b expected %b",
                                              got.changed, exp_r.changed));
                if (got.out_row !== exp_r.out_row)
                    report_mismatch($sformatf("out_row got %0d expected %0d",
                                              got.out_row, exp_r.out_row));
                if (got.out_col !== exp_r.out_col)
                    report_mismatch($sformatf("out_col got %0d expected %0d",
                                              got.out_col, exp_r.out_col));
                if (got.error !== exp_r.error)
                    report_mismatch($sformatf("error got %b expected %b",
                                              got.error, exp_r.error));
            end
        end
    end

    // Main sequence: reset, directed requests, random requests, then drain.
    initial
    begin
        int drain;
        rst_n          = 1'b0;
        req_if.valid   = 1'b0;
        req_if.op      = OP_WRITE;
        req_if.char_in = '0;
        req_if.row_in  = '0;
        req_if.col_in  = '0;
        rsp_if.ready   = 1'b0;
        for (int i = 0; i < CELLS; i++)
            shadow_cells[i] = SPACE_CODE;
        shadow_row   = '0;
        shadow_col   = '0;
        shadow_dirty = 1'b1;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Streams of a blank buffer; the final row clears the changed flag.
        queue_request(OP_STREAM, 8'h00, 3'd0, 5'd0);
        queue_request(OP_STREAM, 8'hFF, 3'(ROWS - 1), 5'd31);
        // Writing the stored space again leaves the flag clear.
        queue_request(OP_WRITE, SPACE_CODE, 3'd7, 5'd31);
        queue_request(OP_WRITE, 8'hFF, 3'd0, 5'd0);
        queue_request(OP_WRITE, 8'h00, 3'd5, 5'd17);
        // Last cell, then a write that wraps to the top left.
        queue_request(OP_SETPOS, 8'hAA, 3'(ROWS), 5'(COLUMNS - 1));
        queue_request(OP_WRITE, 8'h7E, 3'd0, 5'd0);
        // Rejected positions: row zero, row above the last, column past the end.
        queue_request(OP_SETPOS, 8'h00, 3'd0, 5'd0);
        queue_request(OP_SETPOS, 8'h00, 3'(ROWS + 1), 5'd3);
        queue_request(OP_SETPOS, 8'hFF, 3'd7, 5'd31);
        queue_request(OP_SETPOS, 8'h55, 3'd1, 5'(COLUMNS));
        queue_request(OP_SETPOS, 8'h00, 3'd1, 5'd0);
        // Rejected stream rows.
        queue_request(OP_STREAM, 8'h00, 3'(ROWS), 5'd0);
        queue_request(OP_STREAM, 8'hFF, 3'd7, 5'd31);
        // End of a row moves the cursor to the start of the next one.
        queue_request(OP_SETPOS, 8'h00, 3'd1, 5'(COLUMNS - 1));
        queue_request(OP_WRITE, 8'h5A, 3'd0, 5'd0);
        queue_request(OP_SETPOS, 8'h00, 3'd3, 5'd10);
        queue_request(OP_WRITE, 8'h80, 3'd0, 5'd0);
        queue_request(OP_STREAM, 8'h00, 3'd0, 5'd0);
        queue_request(OP_STREAM, 8'h00, 3'd1, 5'd0);
        queue_request(OP_STREAM, 8'h00, 3'(ROWS - 1), 5'd0);
        queue_request(OP_CLEAR, 8'hFF, 3'd7, 5'd31);
        queue_request(OP_STREAM, 8'h00, 3'(ROWS - 1), 5'd0);
        queue_request(OP_STREAM, 8'h00, 3'd2, 5'd0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
            pending_reqs.push_back(make_random_request());

        while (pending_reqs.size() != 0 || accepted_count != sent_count)
            @(posedge clk);

        drain = 0;
        while (expected_responses.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        if (expected_responses.size() != 0)
            report_mismatch($sformatf("%0d expected responses never arrived",
                                      expected_responses.size()));
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("PASS text_display_buffer_with_cursor");
        else
            $display("FAIL text_display_buffer_with_cursor");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #1000000;
        $display("FAIL text_display_buffer_with_cursor");
        $finish;
    end

endmodule
